// File: src/crlf_line_assembler_top_defines.svh
`ifndef CRLF_LINE_ASSEMBLER_TOP_DEFINES_SVH
`define CRLF_LINE_ASSEMBLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define CLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define CLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define CLA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/crlf_la_pkg.sv
`default_nettype none

package crlf_la_pkg;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr;
    } t_store_ctl;

endpackage

`default_nettype wire

// File: src/crlf_la_store.sv
`default_nettype none

module crlf_la_store #(
    parameter int LINE_BYTES = 64,
    parameter int AW         = 6
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire crlf_la_pkg::t_store_ctl i_ctl,
    input  wire  [AW-1:0]             i_wr_addr,
    input  wire  [7:0]                i_wr_data,
    input  wire  [AW-1:0]             i_rd_addr,
    output logic [7:0]                o_rd_data
);

    logic [7:0]            r_mem [LINE_BYTES];
    logic [LINE_BYTES-1:0] r_valid;
    logic [7:0]            r_rd_data;
    logic                  r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr];
            end
        end
    end

    // unwritten entries read as zero
    assign o_rd_data = r_rd_ok ? r_rd_data : 8'h00;

endmodule

`default_nettype wire

// File: src/crlf_line_assembler_top.sv
// CRLF line assembler. Received bytes enter on the s_axis side at one per cycle while no delivery
// runs, and are stored in a LINE_BYTES-entry line buffer; CR followed by LF completes a line, CR
// followed by anything else drops it, and a full buffer wraps its count to zero. When delivery is
// enabled, a completed line goes out on the m_axis side as the whole buffer in index order (stale
// and zero bytes included) with tlast on the final byte, after which the buffer reads as zeros
// again. Each byte of a delivery takes a memory read state and then an output state; the
// controller issues the next read only once the current byte has been accepted, and no request is
// taken during a delivery. The buffer needs no clearing pass after reset: per-entry valid bits
// make unwritten entries read zero.
`default_nettype none
`include "crlf_line_assembler_top_defines.svh"

module crlf_line_assembler_top #(
    parameter int LINE_BYTES = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire        i_cfg_wr_data,   // deliver_enable
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,    // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] line_byte
    output logic       m_axis_tlast     // line_last
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam logic [AW-1:0] LAST_IDX = AW'(LINE_BYTES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHOW
    } t_state;

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_count, n_count;
    logic                    r_seen_cr, n_seen_cr;
    logic                    r_line_done, n_line_done;
    logic                    r_deliver;
    logic [AW-1:0]           r_idx, n_idx;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_last, n_out_last;
    crlf_la_pkg::t_store_ctl store_ctl;
    logic                    in_take;
    logic                    out_take;
    logic                    cr_take;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign cr_take       = in_take && !r_line_done && !r_seen_cr
                           && (s_axis_tdata == crlf_la_pkg::CHAR_CR);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_seen_cr   = r_seen_cr;
        n_line_done = r_line_done;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        store_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (!r_line_done) begin
                        if (r_seen_cr) begin
                            if (s_axis_tdata == crlf_la_pkg::CHAR_LF) begin
                                n_line_done = 1'b1;
                            end else begin
                                n_count   = '0;
                                n_seen_cr = 1'b0;
                            end
                        end else if (cr_take) begin
                            n_seen_cr = 1'b1;
                        end else begin
                            store_ctl.wr_en = 1'b1;
                            n_count = (r_count == LAST_IDX) ? '0 : r_count + 1'b1;
                        end
                    end
                    if (n_line_done && r_deliver) begin
                        n_state     = S_READ;
                        n_idx       = '0;
                        n_count     = '0;
                        n_seen_cr   = 1'b0;
                        n_line_done = 1'b0;
                    end
                end
            end
            S_READ: begin
                store_ctl.rd_en = 1'b1;
                n_out_valid     = 1'b1;
                n_out_last      = (r_idx == LAST_IDX);
                n_state         = S_SHOW;
            end
            S_SHOW: begin
                if (out_take) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        store_ctl.clr = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_seen_cr   <= 1'b0;
            r_line_done <= 1'b0;
            r_deliver   <= 1'b1;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_seen_cr   <= n_seen_cr;
            r_line_done <= n_line_done;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
            if (i_cfg_wr_en) begin
                r_deliver <= i_cfg_wr_data;
            end
        end
    end

    crlf_la_store #(
        .LINE_BYTES (LINE_BYTES),
        .AW         (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (store_ctl),
        .i_wr_addr  (r_count),
        .i_wr_data  (s_axis_tdata),
        .i_rd_addr  (r_idx),
        .o_rd_data  (m_axis_tdata)
    );

    `CLA_ASSERT_IMPLY(a_no_take_during_dump, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `CLA_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, out_take && m_axis_tlast, s_axis_tready)
    `CLA_ASSERT_NEXT(a_cr_arms, i_clk, i_rst_n, cr_take, r_seen_cr)
    `CLA_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= LAST_IDX)

endmodule

`default_nettype wire

// File: test/crlf_line_assembler_top_test.sv
`timescale 1ns / 1ps

module crlf_line_assembler_top_test;

    localparam int LINE_BYTES       = 64;
    localparam int SETTLE_CYCLES    = 2 * LINE_BYTES + 8;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int DIR_ROWS         = 22;
    localparam time RUN_LIMIT       = 10_000_000;

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_QUIET,
        ROW_BLANK_LINE
    } t_row_kind;

    typedef struct packed {
        logic [7:0] rx;
        t_row_kind  kind;
    } t_dir_row;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_line_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    logic [7:0] line_mem [LINE_BYTES];
    int         fill_cnt;
    bit         cr_armed;
    bit         line_held;
    bit         deliver_en;

    t_line_beat line_out_q [$];
    t_line_beat due_beat;
    int         err_cnt;
    int         rx_taken;
    bit         src_idle_on;
    bit         sink_idle_on;
    bit         sink_hold_req;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{crlf_la_pkg::CHAR_CR, ROW_QUIET},
        '{crlf_la_pkg::CHAR_LF, ROW_BLANK_LINE},
        '{8'h00, ROW_QUIET},
        '{8'hff, ROW_QUIET},
        '{crlf_la_pkg::CHAR_CR, ROW_QUIET},
        '{crlf_la_pkg::CHAR_LF, ROW_MODEL},
        '{8'h41, ROW_QUIET},
        '{8'h42, ROW_QUIET},
        '{crlf_la_pkg::CHAR_CR, ROW_QUIET},
        '{8'h78, ROW_QUIET},
        '{8'h43, ROW_QUIET},
        '{crlf_la_pkg::CHAR_CR, ROW_QUIET},
        '{crlf_la_pkg::CHAR_LF, ROW_MODEL},
        '{crlf_la_pkg::CHAR_CR, ROW_QUIET},
        '{crlf_la_pkg::CHAR_CR, ROW_QUIET},
        '{crlf_la_pkg::CHAR_LF, ROW_QUIET},
        '{crlf_la_pkg::CHAR_CR, ROW_QUIET},
        '{crlf_la_pkg::CHAR_LF, ROW_MODEL},
        '{8'h55, ROW_QUIET},
        '{8'haa, ROW_QUIET},
        '{crlf_la_pkg::CHAR_CR, ROW_QUIET},
        '{crlf_la_pkg::CHAR_LF, ROW_MODEL}
    };

    crlf_line_assembler_top #(
        .LINE_BYTES(LINE_BYTES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #(RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic clear_line();
        int k;
        for (k = 0; k < LINE_BYTES; k++) begin
            line_mem[k] = 8'h00;
        end
        fill_cnt  = 0;
        cr_armed  = 1'b0;
        line_held = 1'b0;
    endtask

    // Advance the line state by one request; queue the delivered bytes if asked.
    task automatic assemble_rx(input logic [7:0] b, input bit keep);
        int k;
        t_line_beat beat;
        if (!line_held) begin
            if (cr_armed) begin
                if (b != crlf_la_pkg::CHAR_LF) begin
                    fill_cnt = 0;
                    cr_armed = 1'b0;
                end else begin
                    line_held = 1'b1;
                end
            end else if (b == crlf_la_pkg::CHAR_CR) begin
                cr_armed = 1'b1;
            end else begin
                line_mem[fill_cnt] = b;
                fill_cnt = (fill_cnt == LINE_BYTES - 1) ? 0 : fill_cnt + 1;
            end
        end
        if (line_held && deliver_en) begin
            for (k = 0; k < LINE_BYTES; k++) begin
                beat.data = line_mem[k];
                beat.last = (k == LINE_BYTES - 1);
                if (keep) begin
                    line_out_q.push_back(beat);
                end
            end
            clear_line();
        end
    endtask

    task automatic send_rx(input logic [7:0] b, input t_row_kind kind);
        int gap;
        int k;
        t_line_beat beat;
        @(negedge i_clk);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        rx_taken++;
        assemble_rx(b, kind == ROW_MODEL);
        if (kind == ROW_BLANK_LINE) begin
            for (k = 0; k < LINE_BYTES; k++) begin
                beat.data = 8'h00;
                beat.last = (k == LINE_BYTES - 1);
                line_out_q.push_back(beat);
            end
        end
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (line_out_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle_idle();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input bit en);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= en;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        deliver_en = en;
    endtask

    function automatic logic [7:0] line_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == crlf_la_pkg::CHAR_CR) begin
            b = ~b;
        end
        return b;
    endfunction

    task automatic send_line(input int body_len);
        int k;
        for (k = 0; k < body_len; k++) begin
            send_rx(line_char(), ROW_MODEL);
        end
        send_rx(crlf_la_pkg::CHAR_CR, ROW_MODEL);
        send_rx(crlf_la_pkg::CHAR_LF, ROW_MODEL);
    endtask

    task automatic send_mix(input int target);
        int pick;
        int k;
        logic [7:0] b;
        while (rx_taken < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                send_line($urandom_range(0, 12));
            end else if (pick < 14) begin
                send_line($urandom_range(56, 72));
            end else if (pick < 17) begin
                for (k = $urandom_range(0, 6); k > 0; k--) begin
                    send_rx(line_char(), ROW_MODEL);
                end
                send_rx(crlf_la_pkg::CHAR_CR, ROW_MODEL);
                b = 8'($urandom_range(0, 255));
                send_rx((b == crlf_la_pkg::CHAR_LF) ? crlf_la_pkg::CHAR_CR : b, ROW_MODEL);
            end else if (pick < 19) begin
                for (k = $urandom_range(1, 4); k > 0; k--) begin
                    send_rx(8'($urandom_range(0, 255)), ROW_MODEL);
                end
            end else begin
                wait_drain();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (line_out_q.size() == 0) begin
                report_mismatch($sformatf("unexpected line byte %02h", m_axis_tdata));
            end else begin
                due_beat = line_out_q.pop_front();
                if (m_axis_tdata !== due_beat.data) begin
                    report_mismatch($sformatf("line_byte %02h, want %02h",
                                              m_axis_tdata, due_beat.data));
                end
                if (m_axis_tlast !== due_beat.last) begin
                    report_mismatch($sformatf("line_last %0b, want %0b",
                                              m_axis_tlast, due_beat.last));
                end
            end
        end
    end

    initial begin : sink_drive
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 6);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int r;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        err_cnt       = 0;
        rx_taken      = 0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        sink_hold_req = 1'b0;
        deliver_en    = 1'b1;
        clear_line();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_enable(1'b1);

        for (r = 0; r < DIR_ROWS; r++) begin
            send_rx(dir_rows[r].rx, dir_rows[r].kind);
        end

        // Stall the sink while a line completes and the sender keeps pushing.
        sink_hold_req = 1'b1;
        send_line(5);
        send_line(3);
        send_mix(130);

        settle_idle();
        write_enable(1'b0);
        send_line(4);
        for (r = 0; r < 12; r++) begin
            send_rx(8'($urandom_range(0, 255)), ROW_MODEL);
        end
        settle_idle();
        write_enable(1'b1);
        send_rx(8'h5a, ROW_MODEL);
        send_mix(200);

        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_mix(260);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (line_out_q.size() != 0) begin
            report_mismatch($sformatf("%0d line bytes never delivered", line_out_q.size()));
        end
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/crlf_la_pkg.sv
src/crlf_la_store.sv
src/crlf_line_assembler_top.sv
test/crlf_line_assembler_top_test.sv
